// ----- design/e2rm_pkg.sv -----
// Shared types, constants and the arctangent table for the Euler angle to
// rotation matrix core. No dependencies.
package e2rm_pkg;

    localparam int ANGLE_WIDTH       = 16;
    localparam int ELEMENT_FRAC_BITS = 14;
    localparam int CORDIC_STAGES     = 16;

    localparam int WORK_FRAC   = 30;
    localparam int ANGLE_FRAC  = ANGLE_WIDTH - 3;
    localparam int ANGLE_SHIFT = WORK_FRAC - ANGLE_FRAC;
    localparam int OUT_WIDTH   = ELEMENT_FRAC_BITS + 2;
    localparam int Z_WIDTH     = WORK_FRAC + 3;
    localparam int VAL_WIDTH   = WORK_FRAC + 2;
    localparam int PROD_WIDTH  = 2 * VAL_WIDTH;
    localparam int SUM_WIDTH   = PROD_WIDTH + 1;
    localparam int ELEM_WIDTH  = VAL_WIDTH + 2;
    localparam int ELEM_SHIFT  = WORK_FRAC - ELEMENT_FRAC_BITS;

    localparam logic signed [Z_WIDTH-1:0] GAIN_Q    = 33'sd652032874;
    localparam logic signed [Z_WIDTH-1:0] PI_Q      = 33'sd3373259426;
    localparam logic signed [Z_WIDTH-1:0] HALF_PI_Q = 33'sd1686629713;
    localparam logic signed [VAL_WIDTH-1:0] ONE_Q   = VAL_WIDTH'(64'sd1 <<< WORK_FRAC);
    localparam logic signed [SUM_WIDTH-1:0] HALF_LSB_Q =
        SUM_WIDTH'(64'sd1 <<< (WORK_FRAC - 1));
    localparam logic signed [ELEM_WIDTH-1:0] ELEM_RND =
        (ELEM_SHIFT > 0) ? ELEM_WIDTH'(64'sd1 <<< (ELEM_SHIFT - 1)) : '0;
    localparam logic signed [ELEM_WIDTH-1:0] ELEM_LIM =
        ELEM_WIDTH'(64'sd1 <<< ELEMENT_FRAC_BITS);

    typedef enum logic {
        ORDER_ZYX = 1'b0,
        ORDER_XYZ = 1'b1
    } order_t;

    typedef struct packed {
        logic signed [ANGLE_WIDTH-1:0] roll_angle;
        logic signed [ANGLE_WIDTH-1:0] pitch_angle;
        logic signed [ANGLE_WIDTH-1:0] yaw_angle;
    } angles_t;

    typedef struct packed {
        logic signed [OUT_WIDTH-1:0] m00;
        logic signed [OUT_WIDTH-1:0] m01;
        logic signed [OUT_WIDTH-1:0] m02;
        logic signed [OUT_WIDTH-1:0] m10;
        logic signed [OUT_WIDTH-1:0] m11;
        logic signed [OUT_WIDTH-1:0] m12;
        logic signed [OUT_WIDTH-1:0] m20;
        logic signed [OUT_WIDTH-1:0] m21;
        logic signed [OUT_WIDTH-1:0] m22;
    } result_t;

    // Truncated arctangent of 2^-i in Q.30
    function automatic logic signed [Z_WIDTH-1:0] atan_q(input int idx);
        logic signed [Z_WIDTH-1:0] r;
        case (idx)
            0:  r = 33'sd843314856;
            1:  r = 33'sd497837829;
            2:  r = 33'sd263043836;
            3:  r = 33'sd133525158;
            4:  r = 33'sd67021686;
            5:  r = 33'sd33543515;
            6:  r = 33'sd16775850;
            7:  r = 33'sd8388437;
            8:  r = 33'sd4194282;
            9:  r = 33'sd2097149;
            10: r = 33'sd1048575;
            11: r = 33'sd524287;
            12: r = 33'sd262143;
            13: r = 33'sd131071;
            14: r = 33'sd65535;
            15: r = 33'sd32767;
            16: r = 33'sd16383;
            17: r = 33'sd8191;
            18: r = 33'sd4095;
            19: r = 33'sd2047;
            20: r = 33'sd1023;
            21: r = 33'sd511;
            22: r = 33'sd255;
            23: r = 33'sd127;
            24: r = 33'sd63;
            25: r = 33'sd31;
            26: r = 33'sd15;
            27: r = 33'sd7;
            28: r = 33'sd3;
            29: r = 33'sd1;
            default: r = '0;
        endcase
        return r;
    endfunction

endpackage

// ----- design/e2rm_cordic.sv -----
// Pipelined rotation-mode CORDIC: sine and cosine of one angle, one stage
// per iteration. Depends on e2rm_pkg.
module e2rm_cordic (
    input  logic                                   clk,
    input  logic                                   rst_n,
    input  logic                                   in_valid,
    input  logic signed [e2rm_pkg::ANGLE_WIDTH-1:0] angle,
    output logic                                   out_valid,
    output logic signed [e2rm_pkg::VAL_WIDTH-1:0]  cos_val,
    output logic signed [e2rm_pkg::VAL_WIDTH-1:0]  sin_val
);
    import e2rm_pkg::*;

    logic signed [Z_WIDTH-1:0] z_reg [0:CORDIC_STAGES];
    logic signed [Z_WIDTH-1:0] x_reg [0:CORDIC_STAGES];
    logic signed [Z_WIDTH-1:0] y_reg [0:CORDIC_STAGES];
    logic                      neg_reg [0:CORDIC_STAGES];
    logic                      v_reg [0:CORDIC_STAGES];
    logic signed [Z_WIDTH-1:0] z_scaled;
    logic signed [Z_WIDTH-1:0] z_next;
    logic                      neg_next;
    logic signed [VAL_WIDTH-1:0] cos_reg;
    logic signed [VAL_WIDTH-1:0] sin_reg;
    logic                      vout_reg;

    // Scale to Q.30 and fold into plus or minus pi/2
    always_comb
    begin
        z_scaled = Z_WIDTH'(angle) <<< ANGLE_SHIFT;
        z_next   = z_scaled;
        neg_next = 1'b0;
        if (z_scaled > HALF_PI_Q)
        begin
            z_next   = z_scaled - PI_Q;
            neg_next = 1'b1;
        end
        else if (z_scaled < -HALF_PI_Q)
        begin
            z_next   = z_scaled + PI_Q;
            neg_next = 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            v_reg[0] <= 1'b0;
        else
            v_reg[0] <= in_valid;
    end

    always_ff @(posedge clk)
    begin
        z_reg[0]   <= z_next;
        x_reg[0]   <= GAIN_Q;
        y_reg[0]   <= '0;
        neg_reg[0] <= neg_next;
    end

    // One micro-rotation per stage
    for (genvar i = 0; i < CORDIC_STAGES; i++)
    begin : g_stage
        always_ff @(posedge clk or negedge rst_n)
        begin
            if (!rst_n)
                v_reg[i+1] <= 1'b0;
            else
                v_reg[i+1] <= v_reg[i];
        end

        always_ff @(posedge clk)
        begin
            neg_reg[i+1] <= neg_reg[i];
            if (z_reg[i] >= 0)
            begin
                x_reg[i+1] <= x_reg[i] - (y_reg[i] >>> i);
                y_reg[i+1] <= y_reg[i] + (x_reg[i] >>> i);
                z_reg[i+1] <= z_reg[i] - atan_q(i);
            end
            else
            begin
                x_reg[i+1] <= x_reg[i] + (y_reg[i] >>> i);
                y_reg[i+1] <= y_reg[i] - (x_reg[i] >>> i);
                z_reg[i+1] <= z_reg[i] + atan_q(i);
            end
        end
    end

    // Undo the half-turn fold
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            vout_reg <= 1'b0;
        else
            vout_reg <= v_reg[CORDIC_STAGES];
    end

    always_ff @(posedge clk)
    begin
        if (neg_reg[CORDIC_STAGES])
        begin
            cos_reg <= VAL_WIDTH'(-x_reg[CORDIC_STAGES]);
            sin_reg <= VAL_WIDTH'(-y_reg[CORDIC_STAGES]);
        end
        else
        begin
            cos_reg <= VAL_WIDTH'(x_reg[CORDIC_STAGES]);
            sin_reg <= VAL_WIDTH'(y_reg[CORDIC_STAGES]);
        end
    end

    assign out_valid = vout_reg;
    assign cos_val   = cos_reg;
    assign sin_val   = sin_reg;

endmodule

// ----- design/e2rm_matmul.sv -----
// Two-step product of the elementary rotations with rounding, then the
// final rounding and saturation of the nine elements. Depends on e2rm_pkg.
module e2rm_matmul (
    input  logic                                  clk,
    input  logic                                  rst_n,
    input  logic                                  in_valid,
    input  e2rm_pkg::order_t                      order,
    input  logic signed [e2rm_pkg::VAL_WIDTH-1:0] cx,
    input  logic signed [e2rm_pkg::VAL_WIDTH-1:0] sx,
    input  logic signed [e2rm_pkg::VAL_WIDTH-1:0] cy,
    input  logic signed [e2rm_pkg::VAL_WIDTH-1:0] sy,
    input  logic signed [e2rm_pkg::VAL_WIDTH-1:0] cz,
    input  logic signed [e2rm_pkg::VAL_WIDTH-1:0] sz,
    output logic                                  out_valid,
    output e2rm_pkg::result_t                     result
);
    import e2rm_pkg::*;

    function automatic logic signed [ELEM_WIDTH-1:0] round_q(
        input logic signed [SUM_WIDTH-1:0] acc);
        logic signed [SUM_WIDTH-1:0] t;
        t = (acc + HALF_LSB_Q) >>> WORK_FRAC;
        return ELEM_WIDTH'(t);
    endfunction

    function automatic logic signed [OUT_WIDTH-1:0] to_elem(
        input logic signed [ELEM_WIDTH-1:0] v);
        logic signed [ELEM_WIDTH-1:0] r;
        r = (v + ELEM_RND) >>> ELEM_SHIFT;
        if (r > ELEM_LIM)
            r = ELEM_LIM;
        if (r < -ELEM_LIM)
            r = -ELEM_LIM;
        return OUT_WIDTH'(r);
    endfunction

    logic signed [VAL_WIDTH-1:0]  u [0:8];
    logic signed [VAL_WIDTH-1:0]  w [0:8];
    logic signed [PROD_WIDTH-1:0] pa_reg [0:8];
    logic signed [VAL_WIDTH-1:0]  tmp_reg [0:8];
    logic signed [VAL_WIDTH-1:0]  ca_reg, sa_reg, ct_reg, st_reg;
    order_t                       oa_reg, ot_reg, ob_reg;
    logic                         va_reg, vt_reg, vb_reg, vout_reg;
    logic signed [VAL_WIDTH-1:0]  ra [0:2];
    logic signed [VAL_WIDTH-1:0]  rb [0:2];
    logic signed [VAL_WIDTH-1:0]  rp [0:2];
    logic signed [VAL_WIDTH-1:0]  cb, sb;
    logic signed [PROD_WIDTH-1:0] pac_reg [0:2];
    logic signed [PROD_WIDTH-1:0] pbs_reg [0:2];
    logic signed [PROD_WIDTH-1:0] pas_reg [0:2];
    logic signed [PROD_WIDTH-1:0] pbc_reg [0:2];
    logic signed [VAL_WIDTH-1:0]  pp_reg [0:2];
    logic signed [OUT_WIDTH-1:0]  e_next [0:8];
    logic signed [OUT_WIDTH-1:0]  e_reg [0:8];

    // Select factor pairs of the first product
    always_comb
    begin
        if (order == ORDER_ZYX)
        begin
            u[0] = cz;     w[0] = cy;
            u[1] = -sz;    w[1] = ONE_Q;
            u[2] = cz;     w[2] = sy;
            u[3] = sz;     w[3] = cy;
            u[4] = cz;     w[4] = ONE_Q;
            u[5] = sz;     w[5] = sy;
            u[6] = ONE_Q;  w[6] = -sy;
            u[7] = '0;     w[7] = '0;
            u[8] = ONE_Q;  w[8] = cy;
        end
        else
        begin
            u[0] = ONE_Q;  w[0] = cy;
            u[1] = '0;     w[1] = '0;
            u[2] = ONE_Q;  w[2] = sy;
            u[3] = -sx;    w[3] = -sy;
            u[4] = cx;     w[4] = ONE_Q;
            u[5] = -sx;    w[5] = cy;
            u[6] = cx;     w[6] = -sy;
            u[7] = sx;     w[7] = ONE_Q;
            u[8] = cx;     w[8] = cy;
        end
    end

    // Advance valid bits
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            va_reg   <= 1'b0;
            vt_reg   <= 1'b0;
            vb_reg   <= 1'b0;
            vout_reg <= 1'b0;
        end
        else
        begin
            va_reg   <= in_valid;
            vt_reg   <= va_reg;
            vb_reg   <= vt_reg;
            vout_reg <= vb_reg;
        end
    end

    // First product, then its rounding
    always_ff @(posedge clk)
    begin
        for (int k = 0; k < 9; k++)
        begin
            pa_reg[k]  <= u[k] * w[k];
            tmp_reg[k] <= VAL_WIDTH'(round_q(SUM_WIDTH'(pa_reg[k])));
        end
        oa_reg <= order;
        ot_reg <= oa_reg;
        ob_reg <= ot_reg;
        ca_reg <= (order == ORDER_ZYX) ? cx : cz;
        sa_reg <= (order == ORDER_ZYX) ? sx : sz;
        ct_reg <= ca_reg;
        st_reg <= sa_reg;
    end

    // Pick the two live columns of each row for the second product
    always_comb
    begin
        cb = ct_reg;
        sb = st_reg;
        for (int i = 0; i < 3; i++)
        begin
            if (ot_reg == ORDER_ZYX)
            begin
                ra[i] = tmp_reg[3*i+1];
                rb[i] = tmp_reg[3*i+2];
                rp[i] = tmp_reg[3*i];
            end
            else
            begin
                ra[i] = tmp_reg[3*i];
                rb[i] = tmp_reg[3*i+1];
                rp[i] = tmp_reg[3*i+2];
            end
        end
    end

    always_ff @(posedge clk)
    begin
        for (int i = 0; i < 3; i++)
        begin
            pac_reg[i] <= ra[i] * cb;
            pbs_reg[i] <= rb[i] * sb;
            pas_reg[i] <= ra[i] * sb;
            pbc_reg[i] <= rb[i] * cb;
            pp_reg[i]  <= rp[i];
        end
    end

    // Round, saturate and place each row
    always_comb
    begin
        for (int i = 0; i < 3; i++)
        begin
            if (ob_reg == ORDER_ZYX)
            begin
                e_next[3*i]   = to_elem(ELEM_WIDTH'(pp_reg[i]));
                e_next[3*i+1] = to_elem(round_q(SUM_WIDTH'(pac_reg[i])
                                                + SUM_WIDTH'(pbs_reg[i])));
                e_next[3*i+2] = to_elem(round_q(SUM_WIDTH'(pbc_reg[i])
                                                - SUM_WIDTH'(pas_reg[i])));
            end
            else
            begin
                e_next[3*i]   = to_elem(round_q(SUM_WIDTH'(pac_reg[i])
                                                + SUM_WIDTH'(pbs_reg[i])));
                e_next[3*i+1] = to_elem(round_q(SUM_WIDTH'(pbc_reg[i])
                                                - SUM_WIDTH'(pas_reg[i])));
                e_next[3*i+2] = to_elem(ELEM_WIDTH'(pp_reg[i]));
            end
        end
    end

    always_ff @(posedge clk)
    begin
        for (int k = 0; k < 9; k++)
            e_reg[k] <= e_next[k];
    end

    assign out_valid  = vout_reg;
    assign result.m00 = e_reg[0];
    assign result.m01 = e_reg[1];
    assign result.m02 = e_reg[2];
    assign result.m10 = e_reg[3];
    assign result.m11 = e_reg[4];
    assign result.m12 = e_reg[5];
    assign result.m20 = e_reg[6];
    assign result.m21 = e_reg[7];
    assign result.m22 = e_reg[8];

`ifndef SYNTH
    a_elem_range: assert property (@(posedge clk) disable iff (!rst_n)
        vout_reg |-> (e_reg[0] <= ELEM_LIM && e_reg[0] >= -ELEM_LIM &&
                      e_reg[4] <= ELEM_LIM && e_reg[4] >= -ELEM_LIM &&
                      e_reg[8] <= ELEM_LIM && e_reg[8] >= -ELEM_LIM))
        else $error("matrix element beyond plus or minus one");
    a_valid_chain: assert property (@(posedge clk) disable iff (!rst_n)
        vout_reg |-> $past(va_reg, 3))
        else $error("result without an item in the first product stage");
    a_valid_entry: assert property (@(posedge clk) disable iff (!rst_n)
        vout_reg |-> $past(in_valid, 4))
        else $error("result without an entering item");
`endif

endmodule

// ----- design/euler_to_rotation_matrix_core.sv -----
// Top level: Euler angles to 3x3 rotation matrix, three CORDIC pipelines
// feeding the matrix product pipeline. Depends on e2rm_pkg, e2rm_cordic, e2rm_matmul.
//
//   channel   signals                        direction  accepted when
//   command   start, busy, angles            in         start && !busy
//   result    done, result                   out        every cycle done is high
//   config    cfg_valid, cfg_ready, cfg_data in         cfg_valid && cfg_ready
//
// One item enters per cycle; each result passes through 1 fold stage, 16 CORDIC
// stages, 1 sign stage and 4 product/rounding stages.
// busy stays low: the pipeline never stalls, and done is high for a single cycle per result.
// Reset clears valid bits and sets the order to Z*Y*X.
module euler_to_rotation_matrix_core (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              start,
    output logic              busy,
    input  e2rm_pkg::angles_t angles,
    output logic              done,
    output e2rm_pkg::result_t result,
    input  logic              cfg_valid,
    output logic              cfg_ready,
    input  logic              cfg_data
);
    import e2rm_pkg::*;

    order_t                      order_reg;
    logic                        accept;
    logic                        vx, vy, vz;
    logic signed [VAL_WIDTH-1:0] cx, sx, cy, sy, cz, sz;

    assign busy      = 1'b0;
    assign cfg_ready = 1'b1;
    assign accept    = start && !busy;

    // Hold the rotation order
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            order_reg <= ORDER_ZYX;
        else if (cfg_valid && cfg_ready)
            order_reg <= order_t'(cfg_data);
    end

    e2rm_cordic u_cordic_x (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (accept),
        .angle     (angles.roll_angle),
        .out_valid (vx),
        .cos_val   (cx),
        .sin_val   (sx)
    );

    e2rm_cordic u_cordic_y (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (accept),
        .angle     (angles.pitch_angle),
        .out_valid (vy),
        .cos_val   (cy),
        .sin_val   (sy)
    );

    e2rm_cordic u_cordic_z (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (accept),
        .angle     (angles.yaw_angle),
        .out_valid (vz),
        .cos_val   (cz),
        .sin_val   (sz)
    );

    e2rm_matmul u_matmul (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (vx && vy && vz),
        .order     (order_reg),
        .cx        (cx),
        .sx        (sx),
        .cy        (cy),
        .sy        (sy),
        .cz        (cz),
        .sz        (sz),
        .out_valid (done),
        .result    (result)
    );

endmodule

// ----- tb/testbench.sv -----
// Self-checking testbench for euler_to_rotation_matrix_core: directed table, then random
// angle triples, checked against a bit-exact CORDIC / matrix product predictor.
// Depends on e2rm_pkg and the core.
module testbench;
    timeunit 1ns;
    timeprecision 1ps;
    import e2rm_pkg::*;

    typedef longint mat_t [3][3];

    typedef struct {
        logic signed [15:0] roll;
        logic signed [15:0] pitch;
        logic signed [15:0] yaw;
        bit                 typed_in;
        result_t            matrix;
    } row_t;

    localparam int SETTLE_CYCLES = 40;
    localparam longint GAIN = 652032874;
    localparam longint PI_W = 64'd3373259426;
    localparam longint HALF_PI_W = 1686629713;
    localparam longint ATAN_TBL [16] = '{843314856, 497837829, 263043836, 133525158,
        67021686, 33543515, 16775850, 8388437, 4194282, 2097149, 1048575, 524287,
        262143, 131071, 65535, 32767};
    localparam result_t IDENTITY = '{16'sd16384, 16'sd0, 16'sd0, 16'sd0, 16'sd16384,
        16'sd0, 16'sd0, 16'sd0, 16'sd16384};

    logic    clk;
    logic    rst_n;
    logic    start;
    logic    busy;
    angles_t angles;
    logic    done;
    result_t result;
    logic    cfg_valid;
    logic    cfg_ready;
    logic    cfg_data;

    order_t  order_model;
    result_t pending_matrices [$];
    int      mismatches;

    euler_to_rotation_matrix_core dut (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (start),
        .busy     (busy),
        .angles   (angles),
        .done     (done),
        .result   (result),
        .cfg_valid(cfg_valid),
        .cfg_ready(cfg_ready),
        .cfg_data (cfg_data)
    );

    initial
    begin
        clk = 1'b0;
        forever #1 clk = ~clk;
    end

    // Hard stop on a hang
    initial
    begin
        #2ms;
        $display("TB_ERROR");
        $finish;
    end

    // Sine and cosine of a Q3.13 angle, Q.30, with fold beyond plus or minus pi/2
    task automatic sin_cos(input logic signed [15:0] ang, output longint c, output longint s);
        longint z;
        longint x;
        longint y;
        longint dx;
        longint dy;
        bit     neg;
        z = longint'(ang) <<< 17;
        x = GAIN;
        y = 0;
        neg = 1'b0;
        if (z > HALF_PI_W)
        begin
            z = z - PI_W;
            neg = 1'b1;
        end
        else if (z < -HALF_PI_W)
        begin
            z = z + PI_W;
            neg = 1'b1;
        end
        for (int i = 0; i < 16; i++)
        begin
            dx = y >>> i;
            dy = x >>> i;
            if (z >= 0)
            begin
                x = x - dx;
                y = y + dy;
                z = z - ATAN_TBL[i];
            end
            else
            begin
                x = x + dx;
                y = y - dy;
                z = z + ATAN_TBL[i];
            end
        end
        c = neg ? -x : x;
        s = neg ? -y : y;
    endtask

    // Q.30 product with round half up
    function automatic mat_t mul_q30(mat_t a, mat_t b);
        mat_t   r;
        longint acc;
        for (int i = 0; i < 3; i++)
            for (int j = 0; j < 3; j++)
            begin
                acc = 0;
                for (int k = 0; k < 3; k++)
                    acc = acc + a[i][k] * b[k][j];
                r[i][j] = (acc + (64'sd1 <<< 29)) >>> 30;
            end
        return r;
    endfunction

    function automatic logic signed [15:0] round_sat(longint v);
        longint e;
        e = (v + (64'sd1 <<< 15)) >>> 16;
        if (e > 16384)
            e = 16384;
        if (e < -16384)
            e = -16384;
        return e[15:0];
    endfunction

    task automatic predict_matrix(input angles_t a, output result_t m);
        longint cx, sx, cy, sy, cz, sz;
        mat_t   rx, ry, rz, prod;
        logic [143:0] flat;
        longint one;
        one = 64'sd1 <<< 30;
        sin_cos(a.roll_angle, cx, sx);
        sin_cos(a.pitch_angle, cy, sy);
        sin_cos(a.yaw_angle, cz, sz);
        rx = '{'{one, 0, 0}, '{0, cx, -sx}, '{0, sx, cx}};
        ry = '{'{cy, 0, sy}, '{0, one, 0}, '{-sy, 0, cy}};
        rz = '{'{cz, -sz, 0}, '{sz, cz, 0}, '{0, 0, one}};
        if (order_model == ORDER_ZYX)
            prod = mul_q30(mul_q30(rz, ry), rx);
        else
            prod = mul_q30(mul_q30(rx, ry), rz);
        for (int k = 0; k < 9; k++)
            flat[(8 - k) * 16 +: 16] = round_sat(prod[k / 3][k % 3]);
        m = result_t'(flat);
    endtask

    // Compare each delivered matrix with the oldest pending one
    always @(posedge clk)
    begin
        result_t      want;
        logic [143:0] w;
        logic [143:0] g;
        if (rst_n && done)
        begin
            if (pending_matrices.size() == 0)
            begin
                mismatches++;
                if (mismatches <= 10)
                    $display("unexpected matrix %h", result);
            end
            else
            begin
                want = pending_matrices.pop_front();
                w = want;
                g = result;
                for (int k = 0; k < 9; k++)
                    if (w[(8 - k) * 16 +: 16] !== g[(8 - k) * 16 +: 16])
                    begin
                        mismatches++;
                        if (mismatches <= 10)
                            $display("m%0d%0d: expected %0d got %0d", k / 3, k % 3,
                                $signed(w[(8 - k) * 16 +: 16]),
                                $signed(g[(8 - k) * 16 +: 16]));
                    end
            end
        end
    end

    // Present one item, hold it until accepted, queue its matrix
    task automatic send_angles(input angles_t a, input bit typed_in, input result_t typed,
                               input bit may_idle);
        result_t m;
        if (may_idle)
            while ($urandom_range(99) < 28)
            begin
                @(negedge clk);
                start <= 1'b0;
                angles <= angles_t'(48'({$urandom, $urandom}));
            end
        @(negedge clk);
        start <= 1'b1;
        angles <= a;
        do
            @(posedge clk);
        while (busy);
        predict_matrix(a, m);
        pending_matrices.push_back(typed_in ? typed : m);
    endtask

    // Wait for every pending matrix plus pipeline drain
    task automatic drain;
        @(negedge clk);
        start <= 1'b0;
        while (pending_matrices.size() != 0)
            @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    task automatic write_order(input order_t o);
        @(negedge clk);
        cfg_valid <= 1'b1;
        cfg_data <= o;
        do
            @(posedge clk);
        while (!cfg_ready);
        order_model = o;
        @(negedge clk);
        cfg_valid <= 1'b0;
        cfg_data <= 1'($urandom_range(1));
    endtask

    function automatic logic signed [15:0] rand_angle;
        case ($urandom_range(3))
            0: return 16'($urandom);
            1: return 16'($urandom_range(51472) - 25736);
            2: return 16'($urandom_range(200) - 100 + ($urandom_range(1) ? 12868 : -12868));
            default: return $urandom_range(1) ? 16'(25736 - $urandom_range(50))
                                             : 16'(-25736 + $urandom_range(50));
        endcase
    endfunction

    row_t    stim [$];
    angles_t a;

    initial
    begin
        rst_n = 1'b0;
        start = 1'b0;
        angles = '0;
        cfg_valid = 1'b0;
        cfg_data = 1'b0;
        order_model = ORDER_ZYX;
        mismatches = 0;

        // Zero, range extremes, full field extremes, the pi/2 fold boundary
        stim.push_back('{0, 0, 0, 1, IDENTITY});
        stim.push_back('{25736, 0, 0, 0, '0});
        stim.push_back('{-25736, 0, 0, 0, '0});
        stim.push_back('{0, 25736, 0, 0, '0});
        stim.push_back('{0, -25736, 0, 0, '0});
        stim.push_back('{0, 0, 25736, 0, '0});
        stim.push_back('{0, 0, -25736, 0, '0});
        stim.push_back('{25736, 25736, 25736, 0, '0});
        stim.push_back('{-25736, -25736, -25736, 0, '0});
        stim.push_back('{32767, -32768, 32767, 0, '0});
        stim.push_back('{-32768, 32767, -32768, 0, '0});
        stim.push_back('{12867, 12868, -12867, 0, '0});
        stim.push_back('{-12868, -12867, 12868, 0, '0});
        stim.push_back('{0, 12868, 0, 0, '0});
        stim.push_back('{0, -12868, 0, 0, '0});
        stim.push_back('{1, -1, 1, 0, '0});
        stim.push_back('{6434, -6434, 19302, 0, '0});

        repeat (10) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        // Walk the table under both orders; the reset order comes first
        for (int pass = 0; pass < 2; pass++)
        begin
            if (pass == 1)
            begin
                drain();
                write_order(ORDER_XYZ);
            end
            foreach (stim[i])
                send_angles('{stim[i].roll, stim[i].pitch, stim[i].yaw},
                    stim[i].typed_in && pass == 0, stim[i].matrix, 1'b1);
        end
        drain();
        write_order(ORDER_ZYX);

        // Random phases with order changes; phase 2 streams without gaps
        for (int phase = 0; phase < 5; phase++)
        begin
            for (int n = 0; n < 400; n++)
            begin
                a.roll_angle = rand_angle();
                a.pitch_angle = rand_angle();
                a.yaw_angle = rand_angle();
                send_angles(a, 1'b0, '0, phase != 2);
                if (phase == 3 && n == 200)
                    drain();
            end
            drain();
            write_order(order_t'($urandom_range(1)));
        end
        drain();

        if (mismatches == 0 && pending_matrices.size() == 0)
            $display("TB_OK");
        else
            $display("TB_ERROR");
        $finish;
    end
endmodule
